>>> hdl/klsc_pkg.sv
package klsc_pkg;

    localparam int NUM_LAYERS = 32;
    localparam int LAYER_W    = $clog2(NUM_LAYERS);
    localparam int COUNT_W    = LAYER_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_LAYER   = 3'd0,
        REG_DEFINED_LAYERS  = 3'd1,
        REG_LAYER_KEY_FLAGS = 3'd2,
        REG_SHIFT_OFFSET    = 3'd3,
        REG_NEXT_TARGET     = 3'd4,
        REG_PREVIOUS_TARGET = 3'd5
    } t_reg_index;

    localparam logic [LAYER_W-1:0] DEFAULT_LAYER_RST   = '0;
    localparam logic [COUNT_W-1:0] DEFINED_LAYERS_RST  = COUNT_W'(NUM_LAYERS);
    localparam logic [7:0]         LAYER_KEY_FLAGS_RST = 8'd0;
    localparam logic [7:0]         SHIFT_OFFSET_RST    = 8'd42;
    localparam logic [7:0]         NEXT_TARGET_RST     = 8'd0;
    localparam logic [7:0]         PREVIOUS_TARGET_RST = 8'd1;

    typedef struct packed {
        logic [7:0] key_flags;
        logic [7:0] key_code;
        logic       now_down;
        logic       was_down;
    } t_in_item;

    typedef struct packed {
        logic [7:0]            out_key_flags;
        logic [7:0]            out_key_code;
        logic                  consumed;
        logic [NUM_LAYERS-1:0] layer_mask;
        logic [LAYER_W-1:0]    top_layer;
    } t_out_item;

    typedef struct packed {
        logic [LAYER_W-1:0] default_layer;
        logic [COUNT_W-1:0] defined_layers;
        logic [7:0]         layer_key_flags;
        logic [7:0]         shift_offset;
        logic [7:0]         next_target;
        logic [7:0]         previous_target;
    } t_cfg;

    typedef struct packed {
        logic       turn_on;
        logic       turn_off;
        logic [7:0] layer;
    } t_layer_op;

    function automatic logic [COUNT_W-1:0] layer_limit(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] lim;
        lim = (count > COUNT_W'(NUM_LAYERS)) ? COUNT_W'(NUM_LAYERS) : count;
        return lim;
    endfunction

    function automatic logic bit_on(input logic [NUM_LAYERS-1:0] mask,
                                    input logic [7:0] layer);
        logic on;
        on = (layer < 8'(NUM_LAYERS)) && mask[layer[LAYER_W-1:0]];
        return on;
    endfunction

    function automatic logic [LAYER_W-1:0] find_top(input logic [NUM_LAYERS-1:0] mask,
                                                    input logic [COUNT_W-1:0]    limit,
                                                    input logic [LAYER_W-1:0]    base);
        logic [LAYER_W-1:0] top;
        top = base;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (mask[i] && (COUNT_W'(i) < limit) && (LAYER_W'(i) > base)) begin
                top = LAYER_W'(i);
            end
        end
        return top;
    endfunction

endpackage

>>> hdl/klsc_decode.sv
module klsc_decode (
    input  klsc_pkg::t_in_item                i_item,
    input  klsc_pkg::t_cfg                    i_cfg,
    input  logic [klsc_pkg::NUM_LAYERS-1:0]   i_mask,
    input  logic [klsc_pkg::LAYER_W-1:0]      i_top,
    output logic                              o_consumed,
    output klsc_pkg::t_layer_op               o_op
);

    logic       pressed;
    logic       released;
    logic [7:0] target;
    logic [7:0] top_up;
    logic [7:0] top_ext;

    assign pressed  = i_item.now_down && !i_item.was_down;
    assign released = !i_item.now_down && i_item.was_down;
    assign target   = i_item.key_code - i_cfg.shift_offset;
    assign top_ext  = 8'(i_top);
    assign top_up   = top_ext + 8'd1;
    assign o_consumed = (i_item.key_flags == i_cfg.layer_key_flags);

    always_comb begin
        o_op = '0;
        if (o_consumed) begin
            if (i_item.key_code >= i_cfg.shift_offset) begin
                if (target == i_cfg.next_target) begin
                    if (pressed) begin
                        o_op.turn_on = 1'b1;
                        o_op.layer   = top_up;
                    end else if (released) begin
                        o_op.turn_off = 1'b1;
                        o_op.layer    = top_ext;
                    end
                end else if (target == i_cfg.previous_target) begin
                    if (pressed) begin
                        o_op.turn_off = 1'b1;
                        o_op.layer    = top_ext;
                    end else if (released) begin
                        o_op.turn_on = 1'b1;
                        o_op.layer   = top_up;
                    end
                end else if (i_item.now_down) begin
                    o_op.turn_on = 1'b1;
                    o_op.layer   = target;
                end else if (released) begin
                    o_op.turn_off = 1'b1;
                    o_op.layer    = target;
                end
            end else if (pressed) begin
                o_op.layer = i_item.key_code;
                if (klsc_pkg::bit_on(i_mask, i_item.key_code) && (i_item.key_code != 8'd0)) begin
                    o_op.turn_off = 1'b1;
                end else begin
                    o_op.turn_on = 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/klsc_layer_state.sv
module klsc_layer_state (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [klsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [klsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_step,
    input  klsc_pkg::t_layer_op                 i_op,
    output klsc_pkg::t_cfg                      o_cfg,
    output logic [klsc_pkg::NUM_LAYERS-1:0]     o_mask,
    output logic [klsc_pkg::LAYER_W-1:0]        o_top,
    output logic [klsc_pkg::NUM_LAYERS-1:0]     o_next_mask,
    output logic [klsc_pkg::LAYER_W-1:0]        o_next_top
);

    klsc_pkg::t_cfg                    r_cfg;
    logic [klsc_pkg::NUM_LAYERS-1:0]   r_mask;
    logic [klsc_pkg::LAYER_W-1:0]      r_top;

    logic [klsc_pkg::COUNT_W-1:0]      limit;
    logic [klsc_pkg::NUM_LAYERS-1:0]   lay_bit;
    logic                              do_on;
    logic                              do_off;
    logic [klsc_pkg::LAYER_W-1:0]      new_base;
    logic [klsc_pkg::NUM_LAYERS-1:0]   base_mask;
    logic [klsc_pkg::LAYER_W-1:0]      base_top;

    assign limit   = klsc_pkg::layer_limit(r_cfg.defined_layers);
    assign lay_bit = klsc_pkg::NUM_LAYERS'(1) << i_op.layer[klsc_pkg::LAYER_W-1:0];
    assign do_on   = i_op.turn_on && (i_op.layer < 8'(limit))
                     && !klsc_pkg::bit_on(r_mask, i_op.layer);
    assign do_off  = i_op.turn_off && klsc_pkg::bit_on(r_mask, i_op.layer);

    always_comb begin
        o_next_mask = r_mask;
        o_next_top  = r_top;
        if (do_on) begin
            o_next_mask = r_mask | lay_bit;
            if (i_op.layer > 8'(r_top)) begin
                o_next_top = klsc_pkg::find_top(o_next_mask, limit, r_cfg.default_layer);
            end
        end else if (do_off) begin
            o_next_mask = r_mask & ~lay_bit;
            if (i_op.layer == 8'(r_top)) begin
                o_next_top = klsc_pkg::find_top(o_next_mask, limit, r_cfg.default_layer);
            end
        end
    end

    // new base layer: clear the mask, turn the base on if it is below the limit, search above the old base
    assign new_base = i_cfg_data[klsc_pkg::LAYER_W-1:0];

    always_comb begin
        base_mask = '0;
        base_top  = r_top;
        if (klsc_pkg::COUNT_W'(new_base) < limit) begin
            base_mask = klsc_pkg::NUM_LAYERS'(1) << new_base;
            if (new_base > r_top) begin
                base_top = klsc_pkg::find_top(base_mask, limit, r_cfg.default_layer);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_layer   <= klsc_pkg::DEFAULT_LAYER_RST;
            r_cfg.defined_layers  <= klsc_pkg::DEFINED_LAYERS_RST;
            r_cfg.layer_key_flags <= klsc_pkg::LAYER_KEY_FLAGS_RST;
            r_cfg.shift_offset    <= klsc_pkg::SHIFT_OFFSET_RST;
            r_cfg.next_target     <= klsc_pkg::NEXT_TARGET_RST;
            r_cfg.previous_target <= klsc_pkg::PREVIOUS_TARGET_RST;
            r_mask                <= klsc_pkg::NUM_LAYERS'(1) << klsc_pkg::DEFAULT_LAYER_RST;
            r_top                 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                klsc_pkg::REG_DEFAULT_LAYER: begin
                    r_cfg.default_layer <= new_base;
                    r_mask              <= base_mask;
                    r_top               <= base_top;
                end
                klsc_pkg::REG_DEFINED_LAYERS: begin
                    r_cfg.defined_layers <= i_cfg_data[klsc_pkg::COUNT_W-1:0];
                end
                klsc_pkg::REG_LAYER_KEY_FLAGS: r_cfg.layer_key_flags <= i_cfg_data;
                klsc_pkg::REG_SHIFT_OFFSET:    r_cfg.shift_offset    <= i_cfg_data;
                klsc_pkg::REG_NEXT_TARGET:     r_cfg.next_target     <= i_cfg_data;
                klsc_pkg::REG_PREVIOUS_TARGET: r_cfg.previous_target <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (i_step) begin
            r_mask <= o_next_mask;
            r_top  <= o_next_top;
        end
    end

    assign o_cfg  = r_cfg;
    assign o_mask = r_mask;
    assign o_top  = r_top;

endmodule

>>> hdl/keymap_layer_switch_control_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data  (klsc_pkg::t_in_item)
// result    out        o_valid / i_ready    o_data  (klsc_pkg::t_out_item)
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One transfer per cycle while the result side is ready; a result passes through the input
// register, then the layer update and the result register.
// The layer update and the 32-entry top search are combinational between the registers.
// Synchronous active-low reset: mask holds only layer 0, top layer 0, registers at defaults.
// A stalled result holds in the output register while the input register takes
// one more transfer; further input waits until the result drains.
module keymap_layer_switch_control_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  klsc_pkg::t_in_item                i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output klsc_pkg::t_out_item               o_data,
    input  logic                              i_cfg_we,
    input  logic [klsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [klsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                              r_in_vld;
    klsc_pkg::t_in_item                r_in;
    logic                              r_out_vld;
    klsc_pkg::t_out_item               r_out;
    klsc_pkg::t_out_item               n_out;

    logic                              out_free;
    logic                              fire;
    logic                              consumed;
    klsc_pkg::t_layer_op               op;
    klsc_pkg::t_cfg                    cfg;
    logic [klsc_pkg::NUM_LAYERS-1:0]   mask;
    logic [klsc_pkg::LAYER_W-1:0]      top;
    logic [klsc_pkg::NUM_LAYERS-1:0]   next_mask;
    logic [klsc_pkg::LAYER_W-1:0]      next_top;

    assign out_free = !r_out_vld || i_ready;
    assign o_ready  = !r_in_vld || out_free;
    assign fire     = r_in_vld && out_free;

    klsc_decode u_decode (
        .i_item     (r_in),
        .i_cfg      (cfg),
        .i_mask     (mask),
        .i_top      (top),
        .o_consumed (consumed),
        .o_op       (op)
    );

    klsc_layer_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (fire),
        .i_op        (op),
        .o_cfg       (cfg),
        .o_mask      (mask),
        .o_top       (top),
        .o_next_mask (next_mask),
        .o_next_top  (next_top)
    );

    always_comb begin
        n_out.out_key_flags = consumed ? 8'd0 : r_in.key_flags;
        n_out.out_key_code  = consumed ? 8'd0 : r_in.key_code;
        n_out.consumed      = consumed;
        n_out.layer_mask    = next_mask;
        n_out.top_layer     = next_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

>>> verif/keymap_layer_switch_check.sv
`timescale 1ns / 1ps

module keymap_layer_switch_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  klsc_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  klsc_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [klsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [klsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_waiting
);

    logic [4:0]                      base_layer;
    logic [5:0]                      layer_cnt;
    logic [7:0]                      layer_flags;
    logic [7:0]                      shift_off;
    logic [7:0]                      next_tgt;
    logic [7:0]                      prev_tgt;
    logic [klsc_pkg::NUM_LAYERS-1:0] layer_bits;
    int                              top_idx;
    int                              mismatch_total = 0;
    klsc_pkg::t_out_item             pending_results[$];

    function automatic int layer_span();
        return (layer_cnt > 6'd32) ? 32 : int'(layer_cnt);
    endfunction

    function automatic bit layer_is_on(input int layer);
        return (layer >= 0) && (layer < klsc_pkg::NUM_LAYERS) && layer_bits[layer];
    endfunction

    function automatic void search_top(input int base);
        for (int i = layer_span() - 1; i > base; i--) begin
            if (layer_is_on(i)) begin
                top_idx = i;
                return;
            end
        end
        top_idx = base;
    endfunction

    function automatic void raise_layer(input int layer);
        if (layer >= layer_span() || layer_is_on(layer)) return;
        layer_bits[layer] = 1'b1;
        if (layer > top_idx) search_top(int'(base_layer));
    endfunction

    function automatic void drop_layer(input int layer);
        if (!layer_is_on(layer)) return;
        layer_bits[layer] = 1'b0;
        if (layer == top_idx) search_top(int'(base_layer));
    endfunction

    function automatic void set_base(input int layer);
        layer_bits = '0;
        raise_layer(layer);
        base_layer = 5'(layer);
    endfunction

    function automatic klsc_pkg::t_out_item apply_key_event(input klsc_pkg::t_in_item ev);
        klsc_pkg::t_out_item res;
        bit                  pressed_now;
        bit                  released_now;
        int                  tgt;
        pressed_now  = ev.now_down && !ev.was_down;
        released_now = !ev.now_down && ev.was_down;
        res = '0;
        if (ev.key_flags != layer_flags) begin
            res.out_key_flags = ev.key_flags;
            res.out_key_code  = ev.key_code;
        end else begin
            res.consumed = 1'b1;
            if (ev.key_code >= shift_off) begin
                tgt = int'(ev.key_code) - int'(shift_off);
                if (tgt == int'(next_tgt)) begin
                    if (pressed_now) raise_layer(top_idx + 1);
                    else if (released_now) drop_layer(top_idx);
                end else if (tgt == int'(prev_tgt)) begin
                    if (pressed_now) drop_layer(top_idx);
                    else if (released_now) raise_layer(top_idx + 1);
                end else if (ev.now_down) begin
                    if (!layer_is_on(tgt)) raise_layer(tgt);
                end else if (released_now) begin
                    drop_layer(tgt);
                end
            end else if (pressed_now) begin
                if (layer_is_on(int'(ev.key_code)) && ev.key_code != 8'd0)
                    drop_layer(int'(ev.key_code));
                else
                    raise_layer(int'(ev.key_code));
            end
        end
        res.layer_mask = layer_bits;
        res.top_layer  = klsc_pkg::LAYER_W'(top_idx);
        return res;
    endfunction

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        klsc_pkg::t_out_item want;
        if (!i_rst_n) begin
            layer_cnt   = klsc_pkg::DEFINED_LAYERS_RST;
            layer_flags = klsc_pkg::LAYER_KEY_FLAGS_RST;
            shift_off   = klsc_pkg::SHIFT_OFFSET_RST;
            next_tgt    = klsc_pkg::NEXT_TARGET_RST;
            prev_tgt    = klsc_pkg::PREVIOUS_TARGET_RST;
            base_layer  = klsc_pkg::DEFAULT_LAYER_RST;
            layer_bits  = '0;
            top_idx     = 0;
            set_base(int'(klsc_pkg::DEFAULT_LAYER_RST));
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    klsc_pkg::REG_DEFAULT_LAYER:   set_base(int'(i_cfg_data[4:0]));
                    klsc_pkg::REG_DEFINED_LAYERS:  layer_cnt   = i_cfg_data[5:0];
                    klsc_pkg::REG_LAYER_KEY_FLAGS: layer_flags = i_cfg_data;
                    klsc_pkg::REG_SHIFT_OFFSET:    shift_off   = i_cfg_data;
                    klsc_pkg::REG_NEXT_TARGET:     next_tgt    = i_cfg_data;
                    klsc_pkg::REG_PREVIOUS_TARGET: prev_tgt    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result expected none, got %h", $time, i_out_data);
                    mismatch_total++;
                end else begin
                    want = pending_results.pop_front();
                    note_field("out_key_flags", want.out_key_flags, i_out_data.out_key_flags);
                    note_field("out_key_code", want.out_key_code, i_out_data.out_key_code);
                    note_field("consumed", want.consumed, i_out_data.consumed);
                    note_field("layer_mask", want.layer_mask, i_out_data.layer_mask);
                    note_field("top_layer", want.top_layer, i_out_data.top_layer);
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_key_event(i_in_data));
        end
        o_waiting    <= pending_results.size();
        o_mismatches <= mismatch_total;
    end

endmodule

>>> verif/keymap_layer_switch_control_unit_test.sv
`timescale 1ns / 1ps

module keymap_layer_switch_control_unit_test;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    klsc_pkg::t_in_item              i_data;
    logic                            o_valid;
    logic                            i_ready;
    klsc_pkg::t_out_item             o_data;
    logic                            i_cfg_we;
    logic [klsc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [klsc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int                              mismatches;
    int                              waiting;
    int                              sent;
    logic [7:0]                      cur_flags;
    logic [7:0]                      cur_shift;
    logic [7:0]                      cur_next;
    logic [7:0]                      cur_prev;

    keymap_layer_switch_control_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    keymap_layer_switch_check layer_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic klsc_pkg::t_in_item key_event(input logic [7:0] flags,
                                                     input logic [7:0] code,
                                                     input logic now_down,
                                                     input logic was_down);
        klsc_pkg::t_in_item ev;
        ev = '{key_flags: flags, key_code: code, now_down: now_down, was_down: was_down};
        return ev;
    endfunction

    // receiver: open stretches of random length, sometimes long, mixed with stalls of random length
    initial begin
        int run_len;
        int stall_len;
        forever begin
            i_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            stall_len = pause_len();
            if (stall_len > 0) begin
                i_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task automatic send_event(input klsc_pkg::t_in_item ev);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= ev;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
    endtask

    task automatic write_reg(input klsc_pkg::t_reg_index idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [4:0] dl, input logic [5:0] cnt,
                             input logic [7:0] flags, input logic [7:0] sh,
                             input logic [7:0] nx, input logic [7:0] pv);
        logic base_last;
        base_last = 1'($urandom);
        drain();
        if (!base_last) write_reg(klsc_pkg::REG_DEFAULT_LAYER, 8'(dl));
        write_reg(klsc_pkg::REG_DEFINED_LAYERS, 8'(cnt));
        write_reg(klsc_pkg::REG_LAYER_KEY_FLAGS, flags);
        write_reg(klsc_pkg::REG_SHIFT_OFFSET, sh);
        write_reg(klsc_pkg::REG_NEXT_TARGET, nx);
        write_reg(klsc_pkg::REG_PREVIOUS_TARGET, pv);
        if (base_last) write_reg(klsc_pkg::REG_DEFAULT_LAYER, 8'(dl));
        cur_flags = flags;
        cur_shift = sh;
        cur_next  = nx;
        cur_prev  = pv;
    endtask

    // press, hold, release of one layer key; the release is sometimes left out
    task automatic key_burst();
        int         kind;
        int         sum;
        logic [7:0] code;
        kind = $urandom_range(0, 4);
        case (kind)
            0: sum = (cur_shift == 8'd0) ? $urandom_range(0, 255)
                   : $urandom_range(0, (cur_shift > 8'd34) ? 33 : int'(cur_shift) - 1);
            1: sum = int'(cur_shift) + int'(cur_next);
            2: sum = int'(cur_shift) + int'(cur_prev);
            3: sum = int'(cur_shift) + $urandom_range(0, 35);
            default: sum = $urandom_range(0, 255);
        endcase
        code = (sum > 255) ? 8'($urandom) : 8'(sum);
        send_event(key_event(cur_flags, code, 1'b1, 1'b0));
        repeat ($urandom_range(0, 2)) send_event(key_event(cur_flags, code, 1'b1, 1'b1));
        if ($urandom_range(0, 3) != 0) send_event(key_event(cur_flags, code, 1'b0, 1'b1));
        if ($urandom_range(0, 3) == 0) send_event(key_event(cur_flags, code, 1'b0, 1'b0));
    endtask

    task automatic run_random(input int n);
        int r;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_event(key_event(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
            else if (r < 25)
                send_event(key_event(cur_flags, 8'($urandom), 1'($urandom), 1'($urandom)));
            else
                key_burst();
            if (!paused && sent >= n / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cur_flags = klsc_pkg::LAYER_KEY_FLAGS_RST;
        cur_shift = klsc_pkg::SHIFT_OFFSET_RST;
        cur_next  = klsc_pkg::NEXT_TARGET_RST;
        cur_prev  = klsc_pkg::PREVIOUS_TARGET_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_event(key_event(8'hff, 8'hff, 1'b1, 1'b0));
        send_event(key_event(8'h01, 8'h00, 1'b0, 1'b0));
        send_event(key_event(8'h00, 8'h00, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h05, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h05, 1'b0, 1'b1));
        send_event(key_event(8'h00, 8'h1f, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2a, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2a, 1'b0, 1'b1));
        send_event(key_event(8'h00, 8'h05, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2b, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2b, 1'b0, 1'b1));
        send_event(key_event(8'h00, 8'h2c, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2c, 1'b1, 1'b1));
        send_event(key_event(8'h00, 8'h2c, 1'b0, 1'b1));
        send_event(key_event(8'h00, 8'hff, 1'b1, 1'b1));
        send_event(key_event(8'h00, 8'hff, 1'b0, 1'b1));
        send_event(key_event(8'h00, 8'h20, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h29, 1'b1, 1'b0));
        send_event(key_event(8'h00, 8'h2a, 1'b0, 1'b0));
        send_event(key_event(8'h80, 8'h55, 1'b1, 1'b1));
        send_event(key_event(8'h00, 8'h00, 1'b1, 1'b0));

        configure(5'd0, 6'd32, 8'h00, 8'd42, 8'd0, 8'd1);
        run_random(130);
        configure(5'd31, 6'd32, 8'hff, 8'd0, 8'd255, 8'd254);
        run_random(130);
        configure(5'd2, 6'd1, 8'h5a, 8'd10, 8'd3, 8'd3);
        run_random(130);
        configure(5'd0, 6'd8, 8'h81, 8'd255, 8'd0, 8'd1);
        run_random(130);
        configure(5'd7, 6'd16, 8'h3c, 8'd100, 8'd20, 8'd21);
        run_random(130);
        repeat (5) begin
            configure(($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                                  : 5'($urandom_range(0, 31)),
                      ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 4))
                                                  : 6'($urandom_range(1, 32)),
                      8'($urandom),
                      ($urandom_range(0, 4) < 3) ? 8'($urandom_range(20, 60))
                                                 : 8'($urandom),
                      8'($urandom_range(0, 40)),
                      8'($urandom_range(0, 40)));
            run_random(130);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
